// File: rtl/lfu_pkg.sv
package lfu_pkg;

	localparam int ENTRIES_DEF     = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int CAP_W           = 5;
	// touch stamp, orders entries by last access
	localparam int STAMP_W         = 48;

	localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(16);
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_COMMIT
	} ctl_state_t;

	typedef struct packed {
		logic load_req;
		logic issue;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic last_issue;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/lfu_ctrl.sv
module lfu_ctrl import lfu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the result register can take the word
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/lfu_datapath.sv
module lfu_datapath import lfu_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  req_t             in_word,
	input  ctl_cmd_t         cmd,
	output dp_sts_t          sts,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_word
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
	localparam int META_W = COUNT_WIDTH + STAMP_W;

	logic [CAP_W-1:0]   capacity_q;
	req_t               req_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic [FILL_W-1:0]  fill_q;
	logic [STAMP_W-1:0] stamp_q;

	logic [DATA_W-1:0] key_mem  [ENTRIES];
	logic [DATA_W-1:0] data_mem [ENTRIES];
	logic [META_W-1:0] meta_mem [ENTRIES];

	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [DATA_W-1:0] rd_key_s1;
	logic [DATA_W-1:0] rd_data_s1;
	logic [META_W-1:0] rd_meta_s1;

	logic                   hit_found_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [DATA_W-1:0]      hit_data_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;

	logic                   vic_found_q;
	logic [IDX_W-1:0]       vic_idx_q;
	logic [DATA_W-1:0]      vic_key_q;
	logic [COUNT_WIDTH-1:0] vic_cnt_q;
	logic [STAMP_W-1:0]     vic_stamp_q;

	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic out_valid_q;
	rsp_t res_q;

	logic                   slot_ok;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [STAMP_W-1:0]     rd_stamp;
	logic                   vic_better;

	logic                   is_put, cap_zero, do_touch, new_put, do_evict, use_vic, do_insert;
	logic [CMP_W-1:0]       cap_ext, cap_eff, fill_ext;
	logic [IDX_W-1:0]       ins_idx, wr_addr;
	logic [COUNT_WIDTH-1:0] inc_cnt;
	logic [META_W-1:0]      wr_meta;
	logic                   key_we, data_we, meta_we;
	logic [ENTRIES-1:0]     valid_d;
	rsp_t                   rsp;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.load_req) begin
				scan_idx_q <= '0;
			end else if (cmd.issue) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
		end
	end

	assign sts.last_issue = (scan_idx_q == IDX_W'(ENTRIES - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	// table memories, registered read one slot per cycle
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_idx_s1  <= scan_idx_q;
			rd_key_s1  <= key_mem[scan_idx_q];
			rd_data_s1 <= data_mem[scan_idx_q];
			rd_meta_s1 <= meta_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= req_q.key;
		end
		if (data_we) begin
			data_mem[wr_addr] <= req_q.value;
		end
		if (meta_we) begin
			meta_mem[wr_addr] <= wr_meta;
		end
	end

	assign slot_ok    = valid_q[rd_idx_s1];
	assign rd_cnt     = rd_meta_s1[META_W-1:STAMP_W];
	assign rd_stamp   = rd_meta_s1[STAMP_W-1:0];
	assign vic_better = !vic_found_q || (rd_cnt < vic_cnt_q) ||
		((rd_cnt == vic_cnt_q) && (rd_stamp < vic_stamp_q));

	// scan results: first match, lowest count then oldest, first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load_req) begin
			hit_found_q  <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (slot_ok && !hit_found_q && (rd_key_s1 == req_q.key)) begin
				hit_found_q <= 1'b1;
			end
			if (slot_ok && vic_better) begin
				vic_found_q <= 1'b1;
			end
			if (!slot_ok) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (slot_ok && !hit_found_q && (rd_key_s1 == req_q.key)) begin
				hit_idx_q  <= rd_idx_s1;
				hit_data_q <= rd_data_s1;
				hit_cnt_q  <= rd_cnt;
			end
			if (slot_ok && vic_better) begin
				vic_idx_q   <= rd_idx_s1;
				vic_key_q   <= rd_key_s1;
				vic_cnt_q   <= rd_cnt;
				vic_stamp_q <= rd_stamp;
			end
			if (!slot_ok && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	// commit decisions
	always_comb begin
		is_put    = (req_q.mode == MODE_PUT);
		cap_zero  = (capacity_q == '0);
		cap_ext   = CMP_W'(capacity_q);
		cap_eff   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
		fill_ext  = CMP_W'(fill_q);
		do_touch  = hit_found_q && (!is_put || !cap_zero);
		new_put   = is_put && !cap_zero && !hit_found_q;
		do_evict  = new_put && (fill_ext >= cap_eff) && vic_found_q;
		use_vic   = do_evict && (!free_found_q || (vic_idx_q < free_idx_q));
		do_insert = new_put && (use_vic || free_found_q);
		ins_idx   = use_vic ? vic_idx_q : free_idx_q;
		wr_addr   = do_touch ? hit_idx_q : ins_idx;
		inc_cnt   = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_WIDTH'(1);
		wr_meta   = do_touch ? {inc_cnt, stamp_q} : {COUNT_WIDTH'(1), stamp_q};
		key_we    = cmd.commit && do_insert;
		data_we   = cmd.commit && (do_insert || (do_touch && is_put));
		meta_we   = cmd.commit && (do_touch || do_insert);

		// slot occupancy after this commit; an insert into the victim slot keeps it live
		valid_d = valid_q;
		if (cmd.commit && do_evict) begin
			valid_d[vic_idx_q] = 1'b0;
		end
		if (cmd.commit && do_insert) begin
			valid_d[ins_idx] = 1'b1;
		end

		rsp.found       = hit_found_q;
		rsp.read_value  = is_put ? '0 : (hit_found_q ? hit_data_q : MISS_VALUE);
		rsp.evicted     = do_evict;
		rsp.evicted_key = do_evict ? vic_key_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			stamp_q <= '0;
		end else begin
			valid_q <= valid_d;
			if (meta_we) begin
				stamp_q <= stamp_q + STAMP_W'(1);
			end
			if (cmd.commit && do_insert && !do_evict) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = res_q;

`ifndef SYNTHESIS
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("fill count differs from number of valid slots");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= ENTRIES)
		else $error("fill count above table size");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while result register is occupied");

	a_insert_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_insert) |-> (!valid_q[ins_idx] || use_vic))
		else $error("insert over a live slot");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_evict) |=> $past(fill_q) == fill_q)
		else $error("evict and insert changed the fill");
`endif

endmodule

// File: rtl/lfu_cache_table_unit.sv
// lfu key/value table with lru tie break
// one request word at a time: a new word is taken only after the previous one has
// committed its result; the scan reads one slot per cycle from the single read port
// of the key, data and count/stamp memories
// reset (arst_n low, async): table empty, capacity 16, result register empty;
// no clearing pass, so input is taken right after reset
module lfu_cache_table_unit import lfu_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// capacity register write
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	// request words
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_word,
	// result words
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_word
);

	// controller to datapath commands and status
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// sequencer: idle -> scan every slot -> flush read stage -> commit
	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table memories, scan comparators, update logic and result register;
	// recency kept as a per-slot touch stamp, the oldest stamp loses a count tie
	lfu_datapath #(
		.ENTRIES     (ENTRIES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_word     (in_word),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word)
	);

endmodule

// File: tb/sv/lfu_table_checker.sv
`timescale 1ns / 100ps

module lfu_table_checker import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  req_t             in_word,
	input  logic             out_valid,
	input  logic             out_ready,
	input  rsp_t             out_word,
	output int               mismatches,
	output int               outstanding
);

	localparam int SLOTS = ENTRIES_DEF;
	localparam int CNT_W = COUNT_WIDTH_DEF;

	// shadow copy of the table; age 0 is the most recently touched slot
	logic                     slot_live [SLOTS];
	logic signed [DATA_W-1:0] slot_tag  [SLOTS];
	logic signed [DATA_W-1:0] slot_val  [SLOTS];
	logic [CNT_W-1:0]         slot_uses [SLOTS];
	int unsigned              slot_age  [SLOTS];
	int unsigned              fill_level;
	logic [CAP_W-1:0]         cap_reg;

	rsp_t due_rsps [$];

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t lfu check: %s got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic promote(input int s);
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i] && i != s && slot_age[i] < slot_age[s])
				slot_age[i]++;
		slot_age[s] = 0;
	endtask

	// apply one request to the shadow table and return the result word it gives
	task automatic lfu_apply(input req_t w, output rsp_t r);
		int          hit;
		int          victim;
		int          free_slot;
		int unsigned eff_cap;
		hit       = -1;
		victim    = -1;
		free_slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (hit < 0 && slot_live[i] && slot_tag[i] == w.key)
				hit = i;
		eff_cap       = (cap_reg > SLOTS) ? SLOTS : cap_reg;
		r.found       = (hit >= 0);
		r.read_value  = '0;
		r.evicted     = 1'b0;
		r.evicted_key = '0;
		if (w.mode == MODE_GET) begin
			if (hit >= 0) begin
				r.read_value = slot_val[hit];
				if (slot_uses[hit] != '1)
					slot_uses[hit]++;
				promote(hit);
			end else begin
				r.read_value = MISS_VALUE;
			end
		end else if (eff_cap != 0) begin
			if (hit >= 0) begin
				slot_val[hit] = w.value;
				if (slot_uses[hit] != '1)
					slot_uses[hit]++;
				promote(hit);
			end else begin
				if (fill_level >= eff_cap) begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
								(slot_uses[i] == slot_uses[victim] &&
								slot_age[i] > slot_age[victim])))
							victim = i;
					if (victim >= 0) begin
						r.evicted     = 1'b1;
						r.evicted_key = slot_tag[victim];
						for (int i = 0; i < SLOTS; i++)
							if (slot_live[i] && i != victim && slot_age[i] > slot_age[victim])
								slot_age[i]--;
						slot_live[victim] = 1'b0;
						if (fill_level > 0)
							fill_level--;
					end
				end
				for (int i = 0; i < SLOTS; i++)
					if (free_slot < 0 && !slot_live[i])
						free_slot = i;
				if (free_slot >= 0) begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_live[i])
							slot_age[i]++;
					slot_live[free_slot] = 1'b1;
					slot_tag[free_slot]  = w.key;
					slot_val[free_slot]  = w.value;
					slot_uses[free_slot] = CNT_W'(1);
					slot_age[free_slot]  = 0;
					fill_level++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		rsp_t pred;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_live[i] = 1'b0;
				slot_tag[i]  = '0;
				slot_val[i]  = '0;
				slot_uses[i] = '0;
				slot_age[i]  = 0;
			end
			fill_level = 0;
			cap_reg    = CAP_RESET;
			mismatches = 0;
			due_rsps.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (due_rsps.size() == 0) begin
					report_mismatch("result word with none pending", out_word.read_value, '0);
				end else begin
					want = due_rsps.pop_front();
					if (out_word.found !== want.found)
						report_mismatch("found", DATA_W'(out_word.found), DATA_W'(want.found));
					if (out_word.read_value !== want.read_value)
						report_mismatch("read_value", out_word.read_value, want.read_value);
					if (out_word.evicted !== want.evicted)
						report_mismatch("evicted", DATA_W'(out_word.evicted),
							DATA_W'(want.evicted));
					if (out_word.evicted_key !== want.evicted_key)
						report_mismatch("evicted_key", out_word.evicted_key, want.evicted_key);
				end
			end
			if (in_valid && in_ready) begin
				lfu_apply(in_word, pred);
				due_rsps.push_back(pred);
			end
			if (cfg_wr_en)
				cap_reg = cfg_wr_data;
		end
		outstanding = due_rsps.size();
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import lfu_pkg::*;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = CAP_RESET;
	logic             in_valid    = 1'b0;
	req_t             in_word     = '0;
	logic             out_ready   = 1'b0;
	logic             in_ready;
	logic             out_valid;
	rsp_t             out_word;

	int mismatches;
	int outstanding;
	// request words taken by the block so far
	int words_sent = 0;
	// set near the end of the run: no more idling on either side
	bit calm       = 1'b0;
	// the long output hold-off has been done
	bit held       = 1'b0;

	always #1 clk = ~clk;

	lfu_cache_table_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word)
	);

	lfu_table_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// offer one request word and hold it until taken; called right after a rising edge
	// so every drive lands at the edge, then maybe idle for a burst
	task automatic send_word(input logic mode, input logic [DATA_W-1:0] key,
			input logic [DATA_W-1:0] value);
		int gap;
		in_valid      <= 1'b1;
		in_word.mode  <= mode;
		in_word.key   <= key;
		in_word.value <= value;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		// idle bursts fall on random phases of the block's scan
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain everything in flight, then write the capacity register while idle
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// result side: mostly ready, random stall bursts, and one long hold-off partway
	// through so the result register fills and the block stops taking words
	initial begin : result_side
		@(posedge clk);
		forever begin
			if (!held && words_sent >= 700) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		// capacity per random phase: small, zero, above the table size (saturates),
		// lowered below the current fill, full, and just past full
		logic [CAP_W-1:0] phase_cap [9] = '{5'd4, 5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd17,
				5'd8, 5'd16};
		logic [DATA_W-1:0] key_pool [24];
		logic [DATA_W-1:0] key;
		int                eff_cap;
		int                pick_hi;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset capacity of 16
		send_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);   // miss on empty table
		send_word(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_word(MODE_GET, 32'h7fff_ffff, 32'h0000_0000);   // hit, count goes to 2
		send_word(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_word(MODE_PUT, 32'h7fff_ffff, 32'h1234_5678);   // overwrite present key
		send_word(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
		// fill the remaining slots, all with count 1
		for (int k = 1; k <= 13; k++)
			send_word(MODE_PUT, k, ~k);
		// full table: lowest count, oldest of the ties goes out
		send_word(MODE_PUT, 32'd100, 32'h5a5a_a5a5);
		send_word(MODE_GET, 32'd1, 32'h0000_0000);
		send_word(MODE_PUT, 32'd101, 32'ha5a5_5a5a);
		// capacity zero: puts leave the table alone but still report presence
		set_capacity(5'd0);
		send_word(MODE_PUT, 32'd1, 32'hdead_beef);
		send_word(MODE_PUT, 32'd200, 32'hcafe_f00d);
		send_word(MODE_GET, 32'd200, 32'h0000_0000);

		// key pool with the signed extremes; small pools give hits and evictions
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 24; i++)
			key_pool[i] = $urandom;

		for (int p = 0; p < 9; p++) begin
			set_capacity(phase_cap[p]);
			// a few fresh keys per phase so older entries go stale
			for (int i = 0; i < 3; i++)
				key_pool[$urandom_range(4, 23)] = $urandom;
			eff_cap = (phase_cap[p] > ENTRIES_DEF) ? ENTRIES_DEF : phase_cap[p];
			pick_hi = (eff_cap == 0) ? 5 : eff_cap + 3;
			if (pick_hi > 23)
				pick_hi = 23;
			for (int n = 0; n < 160; n++) begin
				if (p == 8 && n >= 100)
					calm = 1'b1;
				if ($urandom_range(0, 99) < 10)
					key = $urandom;
				else
					key = key_pool[$urandom_range(0, pick_hi)];
				send_word($urandom_range(0, 1) ? MODE_PUT : MODE_GET, key, $urandom);
			end
		end

		// let every result word come back, then a latency's worth of quiet
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
